### hdl/vector_length_config_unit_core_assert.svh
// Assertion macros shared by the vector-length configuration unit.
`ifndef VECTOR_LENGTH_CONFIG_UNIT_CORE_ASSERT_SVH
`define VECTOR_LENGTH_CONFIG_UNIT_CORE_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define VLCU_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("vlcu assertion failed");

// Checks that a condition implies another in the same cycle.
`define VLCU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vlcu assertion failed");

// Checks that a condition implies another in the following cycle.
`define VLCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vlcu assertion failed");

`endif

### hdl/vlcu_pkg.sv
// Package with the types, constants and command codes of the vector-length configuration unit.
package vlcu_pkg;

    // Vector register length in bits.
    localparam int VLEN_BITS = 512;

    // Width that holds the largest maximum length (VLEN_BITS itself, LMUL 8 with SEW 8).
    localparam int VLMAX_W = $clog2(VLEN_BITS + 1);

    // Fixed widths of the result fields.
    localparam int VL_W     = 10;
    localparam int BITS_W   = 13;
    localparam int XLEN     = 64;

    // Type word of an illegal configuration: vill alone.
    localparam logic [XLEN-1:0] VILL_WORD = {1'b1, {(XLEN-1){1'b0}}};

    // Instruction forms.
    localparam logic [1:0] CMD_VSETVL  = 2'd0;
    localparam logic [1:0] CMD_VSETVLI = 2'd1;
    localparam logic [1:0] CMD_VSETIVLI = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // Reserved encodings of the type fields.
    localparam logic [2:0] VLMUL_RSVD = 3'd4;
    localparam logic [2:0] VSEW_MAX   = 3'd3;

    // Decoded view of one type word.
    typedef struct packed {
        logic               legal;    // encoding valid and maximum length not zero
        logic [3:0]         ratio;    // log2(SEW / LMUL)
        logic [2:0]         sew_log;  // log2(SEW)
        logic [VLMAX_W-1:0] vlmax;    // VLEN * LMUL / SEW, zero when reserved
    } vtype_info_t;

endpackage

### hdl/vlcu_decode.sv
// Type-word decoder: element width, SEW/LMUL ratio, maximum length and legality.
module vlcu_decode (
    input  logic [vlcu_pkg::XLEN-1:0] type_word,
    output vlcu_pkg::vtype_info_t     info
);
    import vlcu_pkg::*;

    logic [2:0]         vlmul;
    logic [2:0]         vsew;
    logic               enc_ok;
    logic [3:0]         ratio;
    logic [VLMAX_W-1:0] vlmax;

    // Field extraction and reserved-encoding check.
    assign vlmul  = type_word[2:0];
    assign vsew   = type_word[5:3];
    assign enc_ok = (type_word[XLEN-1:8] == '0) && (vlmul != VLMUL_RSVD) &&
                    (vsew <= VSEW_MAX);

    // log2(SEW) - log2(LMUL); a fractional LMUL adds eight back to the raw code.
    assign ratio = 4'({1'b0, vsew}) + 4'd3 - 4'({1'b0, vlmul}) + (vlmul[2] ? 4'd8 : 4'd0);

    // The maximum length is the register length shifted right by the ratio.
    assign vlmax = enc_ok ? (VLMAX_W'(VLEN_BITS) >> ratio) : '0;

    always_comb begin
        info.legal   = enc_ok && (vlmax != '0);
        info.ratio   = ratio;
        info.sew_log = enc_ok ? (vsew + 3'd3) : 3'd3;
        info.vlmax   = vlmax;
    end

endmodule

### hdl/vector_length_config_unit_core.sv
// Top level of the vector-length configuration unit.
//
// Each input item carries one vector-configuration instruction (register-type,
// immediate-type or all-immediate form, picked by s_cmd) with its requested length
// and type word. The block keeps the current length and type, and for each item
// returns the new length, the new type word, the maximum length of the requested
// type, the length in bits and the destination-write flag. An item with command
// code 3 is dropped: it gives no result and leaves the state as it was.
// Both channels use valid/ready. An accepted item sits in an input register; the
// decode, compare and select logic then loads the result register and the state
// registers from it once the result register has room. One item is accepted per
// cycle unless the receiver stalls; the state read by an item is the one written by
// the item before it, which is settled at the same edge that loads its result.
// When the receiver stalls, the result register holds and one more item waits in
// the input register; further items are held off until the result is taken.
// Reset (aresetn low, synchronous) empties both registers, sets the length to zero
// and the type to the illegal word with only vill set.
module vector_length_config_unit_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic [vlcu_pkg::XLEN-1:0]    s_avl_value,
    input  logic [4:0]                   s_imm_avl,
    input  logic [vlcu_pkg::XLEN-1:0]    s_vtype_value,
    input  logic                         s_src_is_zero,
    input  logic                         s_dst_is_zero,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [vlcu_pkg::VL_W-1:0]    m_new_vl,
    output logic [vlcu_pkg::XLEN-1:0]    m_new_vtype,
    output logic                         m_vl_updated,
    output logic                         m_vill_flag,
    output logic [vlcu_pkg::VL_W-1:0]    m_max_len,
    output logic [vlcu_pkg::BITS_W-1:0]  m_vl_bits,
    output logic                         m_write_dst
);
    import vlcu_pkg::*;

    `include "vector_length_config_unit_core_assert.svh"

    // Input register.
    logic             in_valid_reg;
    logic [1:0]       cmd_reg;
    logic [XLEN-1:0]  avl_reg;
    logic [4:0]       imm_avl_reg;
    logic [XLEN-1:0]  vtype_reg;
    logic             src_zero_reg;
    logic             dst_zero_reg;

    // Architectural state.
    logic [VL_W-1:0]  cur_len_reg;
    logic [XLEN-1:0]  cur_type_reg;

    // Result register.
    logic             out_valid_reg;
    logic [VL_W-1:0]  new_vl_reg;
    logic [XLEN-1:0]  new_vtype_reg;
    logic             vl_updated_reg;
    logic [VL_W-1:0]  max_len_reg;
    logic [BITS_W-1:0] vl_bits_reg;
    logic             write_dst_reg;

    // Datapath signals.
    vtype_info_t      req_info;
    vtype_info_t      cur_info;
    logic             advance;
    logic             drop;
    logic             src_rule;
    logic             legal;
    logic [XLEN-1:0]  avl;
    logic [XLEN-1:0]  vlmax_ext;
    logic [VL_W-1:0]  vl_next;
    logic [XLEN-1:0]  vtype_next;
    logic             upd_next;
    logic [BITS_W-1:0] bits_next;

    // Decoders for the requested and the current type.
    vlcu_decode u_req_decode (
        .type_word (vtype_reg),
        .info      (req_info)
    );

    vlcu_decode u_cur_decode (
        .type_word (cur_type_reg),
        .info      (cur_info)
    );

    // Handshake: an ignored command always moves on; a result waits for room.
    assign drop    = (cmd_reg == CMD_NONE);
    assign advance = in_valid_reg && (drop || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Length and type selection for one instruction.
    always_comb begin
        src_rule  = (cmd_reg != CMD_VSETIVLI) && src_zero_reg;
        avl       = (cmd_reg == CMD_VSETIVLI) ? XLEN'(imm_avl_reg) : avl_reg;
        vlmax_ext = XLEN'(req_info.vlmax);
        legal     = req_info.legal;
        if (src_rule && dst_zero_reg &&
            (!cur_info.legal || (cur_info.ratio != req_info.ratio))) begin
            legal = 1'b0;
        end
        upd_next = 1'b1;
        if (!legal) begin
            vl_next    = '0;
            vtype_next = VILL_WORD;
        end else begin
            vtype_next = vtype_reg;
            if (src_rule && dst_zero_reg) begin
                vl_next  = cur_len_reg;
                upd_next = 1'b0;
            end else if (src_rule) begin
                vl_next = VL_W'(req_info.vlmax);
            end else if (avl < vlmax_ext) begin
                vl_next = VL_W'(avl);
            end else begin
                vl_next = VL_W'(req_info.vlmax);
            end
        end
        bits_next = legal ? BITS_W'({6'd0, vl_next} << req_info.sew_log) : '0;
    end

    // Input register load.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            cmd_reg      <= s_cmd;
            avl_reg      <= s_avl_value;
            imm_avl_reg  <= s_imm_avl;
            vtype_reg    <= s_vtype_value;
            src_zero_reg <= s_src_is_zero;
            dst_zero_reg <= s_dst_is_zero;
        end
    end

    // State update, once per executed instruction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_len_reg  <= '0;
            cur_type_reg <= VILL_WORD;
        end else if (advance && !drop) begin
            cur_type_reg <= vtype_next;
            if (upd_next) begin
                cur_len_reg <= vl_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && !drop) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && !drop) begin
            new_vl_reg     <= vl_next;
            new_vtype_reg  <= vtype_next;
            vl_updated_reg <= upd_next;
            max_len_reg    <= VL_W'(req_info.vlmax);
            vl_bits_reg    <= bits_next;
            write_dst_reg  <= !dst_zero_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_new_vl     = new_vl_reg;
    assign m_new_vtype  = new_vtype_reg;
    assign m_vl_updated = vl_updated_reg;
    assign m_vill_flag  = new_vtype_reg[XLEN-1];
    assign m_max_len    = max_len_reg;
    assign m_vl_bits    = vl_bits_reg;
    assign m_write_dst  = write_dst_reg;

    // The stored type is either the illegal word or a word with no upper bits set.
    `VLCU_ASSERT_ALWAYS(a_cur_type_form, aclk, aresetn,
        (cur_type_reg == VILL_WORD) || (cur_type_reg[XLEN-1:8] == '0))
    // An illegal result carries a zero length and a zero bit count.
    `VLCU_ASSERT_IMPLY(a_vill_zero, aclk, aresetn, m_valid && m_vill_flag,
        (m_new_vl == '0) && (m_vl_bits == '0) && m_vl_updated)
    // The state follows the result of each executed instruction.
    `VLCU_ASSERT_NEXT(a_state_follows, aclk, aresetn, advance && !drop,
        (cur_type_reg == m_new_vtype) && (!m_vl_updated || (cur_len_reg == m_new_vl)))

endmodule
